// ----- src/marp_pkg.sv -----
`default_nettype none

package marp_pkg;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_RING = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_ANSWER    = 3'd0,
    ACT_CONNECTED = 3'd1,
    ACT_NO_CARRIER = 3'd2,
    ACT_BAD_SPEED = 3'd3,
    ACT_TIMEOUT   = 3'd4
  } action_t;

  localparam logic [6:0]  CHAR_CR       = 7'd13;
  localparam logic [6:0]  CHAR_LF       = 7'd10;
  localparam logic [6:0]  CHAR_SPACE    = 7'd32;
  localparam logic [15:0] TIMEOUT_RESET = 16'd90;
  localparam logic [15:0] DEFAULT_SPEED = 16'd300;
  localparam logic [15:0] SPEED_MAX     = 16'hFFFF;

  function automatic logic [6:0] connect_char(input logic [3:0] pos);
    logic [6:0] ch;
    case (pos)
      4'd0:    ch = 7'("C");
      4'd1:    ch = 7'("O");
      4'd2:    ch = 7'("N");
      4'd3:    ch = 7'("N");
      4'd4:    ch = 7'("E");
      4'd5:    ch = 7'("C");
      4'd6:    ch = 7'("T");
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] no_carrier_char(input logic [3:0] pos);
    logic [6:0] ch;
    case (pos)
      4'd0:    ch = 7'("N");
      4'd1:    ch = 7'("O");
      4'd2:    ch = 7'(" ");
      4'd3:    ch = 7'("C");
      4'd4:    ch = 7'("A");
      4'd5:    ch = 7'("R");
      4'd6:    ch = 7'("R");
      4'd7:    ch = 7'("I");
      4'd8:    ch = 7'("E");
      4'd9:    ch = 7'("R");
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [15:0] map_rate(input logic [15:0] s);
    logic [15:0] r;
    if (s == 16'd300 || s == 16'd600 || s == 16'd1200 || s == 16'd2400 ||
        s == 16'd4800 || s == 16'd9600) begin
      r = s;
    end else if (s > 16'd4800 && s < 16'd9600) begin
      r = 16'd9600;
    end else if (s > 16'd9600 && s <= 16'd19200) begin
      r = 16'd19200;
    end else if (s > 16'd19200 && s <= 16'd38400) begin
      r = 16'd38400;
    end else begin
      r = 16'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/marp_if.sv -----
`default_nettype none

interface marp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_char;
  logic       ring_active;

  modport source (output valid, command, rx_char, ring_active, input ready);
  modport sink (input valid, command, rx_char, ring_active, output ready);
endinterface

interface marp_out_if;
  logic                valid;
  logic                ready;
  marp_pkg::action_t   action;
  logic [15:0]         reported_speed;
  logic [15:0]         baud_rate;

  modport source (output valid, action, reported_speed, baud_rate, input ready);
  modport sink (input valid, action, reported_speed, baud_rate, output ready);
endinterface

interface marp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink (input valid, timeout_ticks, output ready);
endinterface

`default_nettype wire

// ----- src/modem_answer_response_parser.sv -----
`default_nettype none

// Answers a modem call and parses its response lines. Items on in_ch are ring
// samples, timer ticks or received characters; one item is taken every clock
// cycle when the result side keeps up. Each accepted item is held in an input
// register, processed in a single pass against the call and line state, and
// its result, if any, is registered in the result register that drives out_ch.
// A ring sample while waiting yields the answer request; a CONNECT line yields
// connected (final until reset) or a bad-speed hang up; an exact NO CARRIER
// line or the timer running out returns the block to waiting. The timeout
// register on cfg_ch is always ready and is latched into the response timer
// when a call is answered. Lines keep at most LINE_CAP-1 characters.
module modem_answer_response_parser #(
  parameter int LINE_CAP = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  marp_in_if.sink     in_ch,
  marp_out_if.source  out_ch,
  marp_cfg_if.sink    cfg_ch
);
  import marp_pkg::*;

  localparam int CntW = $clog2(LINE_CAP);
  localparam logic [CntW-1:0] LastPos = CntW'(LINE_CAP - 1);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_COLLECT,
    PH_CONNECTED
  } call_phase_t;

  typedef enum logic [1:0] {
    LN_HUNT,
    LN_AFTER_NL,
    LN_IN_LINE
  } line_phase_t;

  logic [15:0] timeout_ticks;

  logic       in_valid;
  logic [1:0] cmd;
  logic [6:0] ch;
  logic       ring;

  call_phase_t     call_phase, call_phase_next;
  line_phase_t     line_phase, line_phase_next;
  logic [CntW-1:0] char_count, char_count_next;
  logic            connect_match, connect_match_next;
  logic            carrier_lost_match, carrier_lost_match_next;
  logic            digits_running, digits_running_next;
  logic            digits_found, digits_found_next;
  logic [15:0]     speed_accum, speed_accum_next;
  logic [15:0]     timer_count, timer_count_next;

  logic        res_valid;
  action_t     res_action;
  logic [15:0] res_speed;
  logic [15:0] res_baud;

  logic        advance;

  logic            is_digit, is_upper, start, keep;
  logic [CntW-1:0] kb_count;
  logic            kb_conn, kb_nc, kb_run, kb_found;
  logic [15:0]     kb_accum;
  logic            k_conn, k_nc, k_run, k_found;
  logic [15:0]     k_accum;
  logic [19:0]     prod;
  logic [15:0]     line_speed, line_baud;

  assign advance     = in_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      timeout_ticks <= cfg_ch.timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      cmd  <= in_ch.command;
      ch   <= in_ch.rx_char[6:0];
      ring <= in_ch.ring_active;
    end
  end

  // Character keep step, shared by the first letter of a line and the rest.
  always_comb begin
    is_digit = (ch >= 7'("0")) && (ch <= 7'("9"));
    is_upper = (ch >= 7'("A")) && (ch <= 7'("Z"));
    start    = (line_phase == LN_AFTER_NL);
    kb_count = start ? '0 : char_count;
    kb_conn  = start ? 1'b1 : connect_match;
    kb_nc    = start ? 1'b1 : carrier_lost_match;
    kb_run   = start ? 1'b0 : digits_running;
    kb_found = start ? 1'b0 : digits_found;
    kb_accum = start ? 16'd0 : speed_accum;
    keep     = (kb_count < LastPos);

    k_conn  = kb_conn;
    k_nc    = kb_nc;
    k_run   = kb_run;
    k_found = kb_found;
    k_accum = kb_accum;
    prod    = 20'(kb_accum) * 20'd10 + 20'(ch - 7'("0"));

    if (kb_count < CntW'(7) && ch != connect_char(kb_count[3:0])) begin
      k_conn = 1'b0;
    end
    if (kb_count >= CntW'(10) || ch != no_carrier_char(kb_count[3:0])) begin
      k_nc = 1'b0;
    end
    if (kb_count == CntW'(7)) begin
      k_run = (ch == CHAR_SPACE);
    end else if (kb_count == CntW'(8)) begin
      if (kb_run && is_digit) begin
        k_accum = 16'(ch - 7'("0"));
        k_found = 1'b1;
      end else begin
        k_run = 1'b0;
      end
    end else if (kb_count > CntW'(8) && kb_run) begin
      if (is_digit) begin
        k_accum = (prod > 20'(SPEED_MAX)) ? SPEED_MAX : prod[15:0];
      end else begin
        k_run = 1'b0;
      end
    end

    line_speed = digits_found ? speed_accum : DEFAULT_SPEED;
    line_baud  = map_rate(line_speed);
  end

  always_comb begin
    call_phase_next         = call_phase;
    line_phase_next         = line_phase;
    char_count_next         = char_count;
    connect_match_next      = connect_match;
    carrier_lost_match_next = carrier_lost_match;
    digits_running_next     = digits_running;
    digits_found_next       = digits_found;
    speed_accum_next        = speed_accum;
    timer_count_next        = timer_count;
    res_valid               = 1'b0;
    res_action              = ACT_ANSWER;
    res_speed               = 16'd0;
    res_baud                = 16'd0;

    case (call_phase)
      PH_WAIT: begin
        if (cmd == CMD_RING && ring) begin
          call_phase_next  = PH_COLLECT;
          line_phase_next  = LN_HUNT;
          timer_count_next = timeout_ticks;
          res_valid        = 1'b1;
          res_action       = ACT_ANSWER;
        end
      end
      PH_COLLECT: begin
        case (cmd)
          CMD_CHAR: begin
            case (line_phase)
              LN_HUNT: begin
                if (ch == CHAR_LF) begin
                  line_phase_next = LN_AFTER_NL;
                end
              end
              LN_AFTER_NL, LN_IN_LINE: begin
                if (start && ch == CHAR_LF) begin
                  line_phase_next = LN_AFTER_NL;
                end else if (start && !is_upper) begin
                  line_phase_next = LN_HUNT;
                end else if (!start && (ch == CHAR_CR || ch == CHAR_LF)) begin
                  line_phase_next = LN_HUNT;
                  if (connect_match && char_count >= CntW'(7)) begin
                    res_valid = 1'b1;
                    res_speed = line_speed;
                    if (line_baud != 16'd0) begin
                      call_phase_next = PH_CONNECTED;
                      res_action      = ACT_CONNECTED;
                      res_baud        = line_baud;
                    end else begin
                      call_phase_next = PH_WAIT;
                      res_action      = ACT_BAD_SPEED;
                    end
                  end else if (carrier_lost_match && char_count == CntW'(10)) begin
                    call_phase_next = PH_WAIT;
                    res_valid       = 1'b1;
                    res_action      = ACT_NO_CARRIER;
                  end
                end else begin
                  line_phase_next         = LN_IN_LINE;
                  char_count_next         = kb_count;
                  connect_match_next      = kb_conn;
                  carrier_lost_match_next = kb_nc;
                  digits_running_next     = kb_run;
                  digits_found_next       = kb_found;
                  speed_accum_next        = kb_accum;
                  if (keep) begin
                    char_count_next         = kb_count + CntW'(1);
                    connect_match_next      = k_conn;
                    carrier_lost_match_next = k_nc;
                    digits_running_next     = k_run;
                    digits_found_next       = k_found;
                    speed_accum_next        = k_accum;
                  end
                end
              end
              default: line_phase_next = LN_HUNT;
            endcase
          end
          CMD_TICK: begin
            if (timer_count <= 16'd1) begin
              timer_count_next = 16'd0;
              call_phase_next  = PH_WAIT;
              res_valid        = 1'b1;
              res_action       = ACT_TIMEOUT;
            end else begin
              timer_count_next = timer_count - 16'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      call_phase         <= PH_WAIT;
      line_phase         <= LN_HUNT;
      char_count         <= '0;
      connect_match      <= 1'b0;
      carrier_lost_match <= 1'b0;
      digits_running     <= 1'b0;
      digits_found       <= 1'b0;
      speed_accum        <= 16'd0;
      timer_count        <= 16'd0;
      out_ch.valid       <= 1'b0;
    end else begin
      if (advance) begin
        call_phase         <= call_phase_next;
        line_phase         <= line_phase_next;
        char_count         <= char_count_next;
        connect_match      <= connect_match_next;
        carrier_lost_match <= carrier_lost_match_next;
        digits_running     <= digits_running_next;
        digits_found       <= digits_found_next;
        speed_accum        <= speed_accum_next;
        timer_count        <= timer_count_next;
        out_ch.valid       <= res_valid;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
    if (advance && res_valid) begin
      out_ch.action         <= res_action;
      out_ch.reported_speed <= res_speed;
      out_ch.baud_rate      <= res_baud;
    end
  end

endmodule

`default_nettype wire

// ----- src/marp_checker.sv -----
`default_nettype none

module marp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_action,
  input wire logic [15:0] out_speed,
  input wire logic [15:0] out_baud
);
  import marp_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_speed) && $stable(out_baud))
    else $error("result changed while stalled");

  a_baud_only_connected: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action != ACT_CONNECTED |-> out_baud == 16'd0)
    else $error("baud rate without connect");

  a_connected_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action == ACT_CONNECTED |-> out_baud != 16'd0 &&
      out_speed != 16'd0)
    else $error("connect without rate");

  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_action == ACT_ANSWER || out_action == ACT_NO_CARRIER ||
      out_action == ACT_TIMEOUT) |-> out_speed == 16'd0)
    else $error("speed on non-connect result");

  a_connected_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_action == ACT_CONNECTED |=> !out_valid)
    else $error("result after connect");

endmodule

bind modem_answer_response_parser marp_checker u_marp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_action(out_ch.action),
  .out_speed (out_ch.reported_speed),
  .out_baud  (out_ch.baud_rate)
);

`default_nettype wire
